// ===== hdl/iee_pkg.sv =====
// Shared types and constants for the infix expression evaluator.
`timescale 1ns / 1ps
package iee_pkg;
  localparam int ActionWidth = 4;
  localparam int ValueWidth  = 64;
  localparam int ErrorWidth  = 3;
  localparam int OpWidth     = 3;

  localparam logic [ActionWidth-1:0] ACT_NUMBER = 4'd0;
  localparam logic [ActionWidth-1:0] ACT_PI     = 4'd1;
  localparam logic [ActionWidth-1:0] ACT_E      = 4'd2;
  localparam logic [ActionWidth-1:0] ACT_OPEN   = 4'd3;
  localparam logic [ActionWidth-1:0] ACT_CLOSE  = 4'd4;
  localparam logic [ActionWidth-1:0] ACT_MUL    = 4'd5;
  localparam logic [ActionWidth-1:0] ACT_DIV    = 4'd6;
  localparam logic [ActionWidth-1:0] ACT_ADD    = 4'd7;
  localparam logic [ActionWidth-1:0] ACT_SUB    = 4'd8;
  localparam logic [ActionWidth-1:0] ACT_END    = 4'd9;

  localparam logic [OpWidth-1:0] OPC_OPEN = 3'd2;
  localparam logic [OpWidth-1:0] OPC_MUL  = 3'd4;
  localparam logic [OpWidth-1:0] OPC_DIV  = 3'd5;
  localparam logic [OpWidth-1:0] OPC_ADD  = 3'd6;
  localparam logic [OpWidth-1:0] OPC_SUB  = 3'd7;

  localparam logic [ErrorWidth-1:0] ERR_NONE      = 3'd0;
  localparam logic [ErrorWidth-1:0] ERR_UNDERFLOW = 3'd1;
  localparam logic [ErrorWidth-1:0] ERR_CLOSE     = 3'd2;
  localparam logic [ErrorWidth-1:0] ERR_OPEN      = 3'd3;
  localparam logic [ErrorWidth-1:0] ERR_DIVZERO   = 3'd4;
  localparam logic [ErrorWidth-1:0] ERR_SATURATE  = 3'd5;
  localparam logic [ErrorWidth-1:0] ERR_FULL      = 3'd6;

  // Value source selection for a value stack push.
  typedef enum logic [1:0] {
    VSRC_INPUT,
    VSRC_PI,
    VSRC_E,
    VSRC_ALU
  } vsrc_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               op_push;
    logic [OpWidth-1:0] op_code;
    logic               op_pop;
    logic               op_read;
    logic               val_push;
    vsrc_t              val_src;
    logic               val_pop2;
    logic               val_read;
    logic               alu_start;
    logic [OpWidth-1:0] alu_op;
    logic               flag_en;
    logic [ErrorWidth-1:0] flag_code;
    logic               clear;
  } iee_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic               op_empty;
    logic               op_full;
    logic               val_full;
    logic               val_lt2;
    logic               val_empty;
    logic [OpWidth-1:0] op_top;
    logic               alu_done;
  } iee_status_t;
endpackage

// ===== hdl/iee_stream_if.sv =====
// Valid/ready channel interfaces for tokens and results.
`timescale 1ns / 1ps
interface iee_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic signed [63:0] number_value;
  modport source (output valid, action, number_value, input ready);
  modport sink (input valid, action, number_value, output ready);
endinterface

interface iee_result_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] result_value;
  logic [2:0]  error_code;
  modport source (output valid, result_value, error_code, input ready);
  modport sink (input valid, result_value, error_code, output ready);
endinterface

// ===== hdl/iee_alu.sv =====
// Saturating fixed-point add, subtract, multiply and iterative divide.
`timescale 1ns / 1ps
module iee_alu import iee_pkg::*; #(
  parameter int FRACTION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [OpWidth-1:0]    op,
  input  logic [ValueWidth-1:0] a,
  input  logic [ValueWidth-1:0] b,
  output logic                  done,
  output logic [ValueWidth-1:0] result,
  output logic                  sat,
  output logic                  divzero
);
  localparam int W = ValueWidth;
  localparam int NB = 2 * W;
  localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] PosMax  = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [2:0] {S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_DIV, S_FIT} alu_state_t;
  alu_state_t state;

  logic          neg;
  logic [W-1:0]  ua, ub;
  logic [W-1:0]  mag;
  logic          ovf;
  logic [63:0]   pp_ll, pp_lh, pp_hl, pp_hh;
  logic [NB-1:0] numer;
  logic [W:0]    rem;
  logic [6:0]    cnt;

  logic [W-1:0]  a_mag, b_mag, sum;
  logic [NB-1:0] prod, prod_sh;
  logic [W:0]    rem_sh, rem_sub;
  logic          add_ovf, same;

  always_comb begin
    a_mag = a[W-1] ? (~a + 1'b1) : a;
    b_mag = b[W-1] ? (~b + 1'b1) : b;
    sum = (op == OPC_SUB) ? (a - b) : (a + b);
    same = (a[W-1] == b[W-1]);
    add_ovf = ((op == OPC_SUB) ? !same : same) && (sum[W-1] != a[W-1]);
    prod = {pp_hh, 64'b0} + {32'b0, pp_lh, 32'b0} + {32'b0, pp_hl, 32'b0} +
           {64'b0, pp_ll};
    prod_sh = prod >> FRACTION_BITS;
    rem_sh = {rem[W-1:0], numer[NB-1]};
    rem_sub = rem_sh - {1'b0, ub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      sat <= 1'b0;
      divzero <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            neg <= a[W-1] ^ b[W-1];
            ua <= a_mag;
            ub <= b_mag;
            ovf <= 1'b0;
            if (op == OPC_MUL) begin
              state <= S_MUL0;
            end else if (op == OPC_DIV) begin
              if (b_mag == '0) begin
                result <= '0;
                divzero <= 1'b1;
                done <= 1'b1;
              end else begin
                numer <= {{W{1'b0}}, a_mag} << FRACTION_BITS;
                rem <= '0;
                mag <= '0;
                cnt <= 7'(NB - 1);
                state <= S_DIV;
              end
            end else begin
              result <= add_ovf ? (a[W-1] ? SignBit : PosMax) : sum;
              sat <= add_ovf;
              done <= 1'b1;
            end
          end
        end
        S_MUL0: begin
          pp_ll <= ua[31:0] * ub[31:0];
          pp_lh <= ua[31:0] * ub[63:32];
          state <= S_MUL1;
        end
        S_MUL1: begin
          pp_hl <= ua[63:32] * ub[31:0];
          pp_hh <= ua[63:32] * ub[63:32];
          state <= S_MUL2;
        end
        S_MUL2: begin
          mag <= prod_sh[W-1:0];
          ovf <= (prod_sh[NB-1:W] != '0);
          state <= S_FIT;
        end
        S_DIV: begin
          // One restoring division step per cycle over the 128-bit numerator.
          numer <= numer << 1;
          if (mag[W-1]) begin
            ovf <= 1'b1;
          end
          if (!rem_sub[W]) begin
            rem <= rem_sub;
            mag <= {mag[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            mag <= {mag[W-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= S_FIT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIT: begin
          if (neg) begin
            if (ovf || mag > SignBit) begin
              result <= SignBit;
              sat <= 1'b1;
            end else begin
              result <= ~mag + 1'b1;
            end
          end else if (ovf || mag > PosMax) begin
            result <= PosMax;
            sat <= 1'b1;
          end else begin
            result <= mag;
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/iee_datapath.sv =====
// Operator and value stacks, constants, error register and the ALU.
`timescale 1ns / 1ps
module iee_datapath import iee_pkg::*; #(
  parameter int STACK_DEPTH   = 16,
  parameter int FRACTION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  iee_cmd_t              cmd,
  input  logic [ValueWidth-1:0] in_value,
  output iee_status_t           status,
  output logic [ValueWidth-1:0] val_top,
  output logic [ErrorWidth-1:0] sticky
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(STACK_DEPTH);
  localparam real PiFrac = 0.14159265 * (2.0 ** FRACTION_BITS);
  localparam real EFrac  = 0.71828182 * (2.0 ** FRACTION_BITS);
  // The conversion to an integer already rounds to nearest.
  localparam logic [ValueWidth-1:0] PiVal =
    (ValueWidth'(3) << FRACTION_BITS) + ValueWidth'(longint'(PiFrac));
  localparam logic [ValueWidth-1:0] EVal =
    (ValueWidth'(2) << FRACTION_BITS) + ValueWidth'(longint'(EFrac));

  logic [OpWidth-1:0]    op_mem [STACK_DEPTH];
  logic [ValueWidth-1:0] val_mem [STACK_DEPTH];
  logic [CW-1:0]         op_cnt, val_cnt;
  logic [OpWidth-1:0]    op_rd;
  logic [ValueWidth-1:0] rd_a, rd_b;
  logic [ValueWidth-1:0] push_data;
  logic [ValueWidth-1:0] in_hold;
  logic [CW-1:0]         val_base;
  logic                  alu_done, alu_sat, alu_dz;
  logic [ValueWidth-1:0] alu_res;

  iee_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk, .rst, .start(cmd.alu_start), .op(cmd.alu_op), .a(rd_a), .b(rd_b),
    .done(alu_done), .result(alu_res), .sat(alu_sat), .divzero(alu_dz)
  );

  always_comb begin
    case (cmd.val_src)
      VSRC_INPUT: push_data = in_hold;
      VSRC_PI:    push_data = PiVal;
      VSRC_E:     push_data = EVal;
      default:    push_data = alu_res;
    endcase
    val_base = cmd.val_pop2 ? (val_cnt - CW'(2)) : val_cnt;
  end

  // The push lands after the transfer, once the command is registered, so the operand is held here.
  always_ff @(posedge clk) begin
    in_hold <= in_value;
  end

  // Reads are registered; the controller waits for the read register to load after op_read/val_read.
  always_ff @(posedge clk) begin
    if (cmd.op_read) begin
      op_rd <= op_mem[AW'(op_cnt - 1'b1)];
    end
    if (cmd.val_read) begin
      rd_a <= val_mem[AW'(val_cnt - CW'(2))];
      rd_b <= val_mem[AW'(val_cnt - 1'b1)];
    end
    if (cmd.op_push && op_cnt != Full) begin
      op_mem[AW'(op_cnt)] <= cmd.op_code;
    end
    if (cmd.val_push && val_base != Full) begin
      val_mem[AW'(val_base)] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      op_cnt <= '0;
      val_cnt <= '0;
      sticky <= ERR_NONE;
    end else begin
      if (cmd.op_push && op_cnt != Full) begin
        op_cnt <= op_cnt + 1'b1;
      end else if (cmd.op_pop) begin
        op_cnt <= op_cnt - 1'b1;
      end
      if (cmd.val_push && val_base != Full) begin
        val_cnt <= val_base + 1'b1;
      end else begin
        val_cnt <= val_base;
      end
      if (sticky == ERR_NONE) begin
        if (cmd.flag_en) begin
          sticky <= cmd.flag_code;
        end else if (alu_done && alu_sat) begin
          sticky <= ERR_SATURATE;
        end else if (alu_done && alu_dz) begin
          sticky <= ERR_DIVZERO;
        end
      end
    end
  end

  always_comb begin
    status.op_empty  = (op_cnt == '0);
    status.op_full   = (op_cnt == Full);
    status.val_full  = (val_cnt == Full);
    status.val_lt2   = (val_cnt < CW'(2));
    status.val_empty = (val_cnt == '0);
    status.op_top    = op_rd;
    status.alu_done  = alu_done;
    val_top          = rd_b;
  end
endmodule

// ===== hdl/iee_controller.sv =====
// Token sequencer: precedence rules, reductions, drain and result hand-off.
`timescale 1ns / 1ps
module iee_controller import iee_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  iee_token_if.sink             tok,
  iee_result_if.source          res,
  output iee_cmd_t              cmd,
  input  iee_status_t           status,
  input  logic [ValueWidth-1:0] val_top,
  input  logic [ErrorWidth-1:0] sticky
);
  typedef enum logic [3:0] {
    C_IDLE, C_PEEK, C_DECIDE, C_VREAD, C_VWAIT, C_ALU, C_PUSHOP, C_TREAD, C_TWAIT,
    C_OUT, C_HOLD
  } ctl_state_t;
  ctl_state_t state;
  logic [ActionWidth-1:0] act;
  logic [OpWidth-1:0]     op_cur;

  // A stack push or pop issued last cycle lands in this one, so the next token
  // waits until the stack counts it checks are current.
  always_comb begin
    tok.ready = (state == C_IDLE) && !cmd.op_push && !cmd.op_pop && !cmd.val_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      res.valid <= 1'b0;
      cmd <= '0;
    end else begin
      cmd <= '0;
      case (state)
        C_IDLE: begin
          if (tok.valid && tok.ready) begin
            act <= tok.action;
            op_cur <= 3'(tok.action - 4'd1);
            case (tok.action)
              ACT_NUMBER, ACT_PI, ACT_E: begin
                cmd.val_push <= 1'b1;
                cmd.val_src <= (tok.action == ACT_PI) ? VSRC_PI :
                               (tok.action == ACT_E) ? VSRC_E : VSRC_INPUT;
                if (status.val_full) begin
                  cmd.flag_en <= 1'b1;
                  cmd.flag_code <= ERR_FULL;
                end
              end
              ACT_OPEN: begin
                cmd.op_push <= 1'b1;
                cmd.op_code <= OPC_OPEN;
                if (status.op_full) begin
                  cmd.flag_en <= 1'b1;
                  cmd.flag_code <= ERR_FULL;
                end
              end
              ACT_CLOSE, ACT_MUL, ACT_DIV, ACT_ADD, ACT_SUB, ACT_END: begin
                state <= C_PEEK;
              end
              default: ;
            endcase
          end
        end
        C_PEEK: begin
          // A pop issued on the way here has not reached the count yet.
          if (!cmd.op_pop) begin
            if (status.op_empty) begin
              if (act == ACT_CLOSE) begin
                cmd.flag_en <= 1'b1;
                cmd.flag_code <= ERR_CLOSE;
                state <= C_IDLE;
              end else if (act == ACT_END) begin
                state <= C_TREAD;
              end else begin
                state <= C_PUSHOP;
              end
            end else begin
              cmd.op_read <= 1'b1;
              state <= C_DECIDE;
            end
          end
        end
        C_DECIDE: begin
          if (!cmd.op_read) begin
            if (status.op_top == OPC_OPEN) begin
              if (act == ACT_CLOSE) begin
                cmd.op_pop <= 1'b1;
                state <= C_IDLE;
              end else if (act == ACT_END) begin
                cmd.op_pop <= 1'b1;
                cmd.flag_en <= 1'b1;
                cmd.flag_code <= ERR_OPEN;
                state <= C_PEEK;
              end else begin
                state <= C_PUSHOP;
              end
            end else if (act == ACT_CLOSE || act == ACT_END ||
                         status.op_top[2:1] <= op_cur[2:1]) begin
              cmd.op_pop <= 1'b1;
              if (status.val_lt2) begin
                cmd.flag_en <= 1'b1;
                cmd.flag_code <= ERR_UNDERFLOW;
                state <= C_PEEK;
              end else begin
                cmd.val_read <= 1'b1;
                state <= C_VREAD;
              end
            end else begin
              state <= C_PUSHOP;
            end
          end
        end
        C_VREAD: state <= C_VWAIT;
        C_VWAIT: begin
          cmd.alu_start <= 1'b1;
          cmd.alu_op <= status.op_top;
          state <= C_ALU;
        end
        C_ALU: begin
          if (status.alu_done) begin
            cmd.val_pop2 <= 1'b1;
            cmd.val_push <= 1'b1;
            cmd.val_src <= VSRC_ALU;
            state <= C_PEEK;
          end
        end
        C_PUSHOP: begin
          cmd.op_push <= 1'b1;
          cmd.op_code <= op_cur;
          if (status.op_full) begin
            cmd.flag_en <= 1'b1;
            cmd.flag_code <= ERR_FULL;
          end
          state <= C_IDLE;
        end
        C_TREAD: begin
          cmd.val_read <= 1'b1;
          state <= C_TWAIT;
        end
        C_TWAIT: state <= C_OUT;
        C_OUT: begin
          if (status.val_empty) begin
            res.result_value <= '0;
            res.error_code <= (sticky == ERR_NONE) ? ERR_UNDERFLOW : sticky;
          end else begin
            res.result_value <= val_top;
            res.error_code <= sticky;
          end
          res.valid <= 1'b1;
          cmd.clear <= 1'b1;
          state <= C_HOLD;
        end
        C_HOLD: begin
          if (res.ready) begin
            res.valid <= 1'b0;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/infix_expression_evaluator.sv =====
// Top level of the two-stack infix expression evaluator.
//
//   channel  dir  payload
//   tok      in   action[3:0], number_value[63:0] signed Q32.32
//   res      out  result_value[63:0] signed Q32.32, error_code[2:0]
//
// An operand or open token is pushed after its transfer, and the next token waits
// until the push has landed. An operator or close reads and inspects the operator
// stack entry by entry, and each reduction fetches two operands, runs the unit
// and writes the result back; divide produces one quotient bit per cycle. End
// drains the stacks the same way and then holds the result until it is
// transferred. Reset is synchronous on rst.
`timescale 1ns / 1ps
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int STACK_DEPTH   = 16,
  parameter int FRACTION_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  iee_token_if.sink    tok,
  iee_result_if.source res
);
  iee_cmd_t              cmd;
  iee_status_t           status;
  logic [ValueWidth-1:0] val_top;
  logic [ErrorWidth-1:0] sticky;

  iee_controller u_ctl (
    .clk, .rst, .tok, .res, .cmd, .status, .val_top, .sticky
  );

  iee_datapath #(.STACK_DEPTH(STACK_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk, .rst, .cmd, .in_value(tok.number_value), .status, .val_top, .sticky
  );
endmodule

// ===== bench/iee_checker.sv =====
// Evaluation checker: watches both channels, computes expected results and compares them.
`timescale 1ns / 1ps
module iee_checker import iee_pkg::*; #(
  parameter int STACK_DEPTH   = 16,
  parameter int FRACTION_BITS = 32
) (
  input  logic  clk,
  input  logic  rst,
  iee_token_if  tok,
  iee_result_if res,
  output int    fail_count,
  output int    pending_count,
  output int    checked_count
);
  typedef struct {
    logic [ValueWidth-1:0] value;
    logic [ErrorWidth-1:0] code;
  } outcome_t;

  localparam logic [63:0] MinValue = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxValue = 64'h7FFF_FFFF_FFFF_FFFF;

  outcome_t expected_outcomes[$];
  logic [OpWidth-1:0]    op_stack[STACK_DEPTH];
  logic [ValueWidth-1:0] val_stack[STACK_DEPTH];
  int unsigned           op_depth;
  int unsigned           val_depth;
  logic [ErrorWidth-1:0] first_error;

  assign pending_count = expected_outcomes.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void raise(input logic [ErrorWidth-1:0] code);
    if (first_error == ERR_NONE) first_error = code;
  endfunction

  // Constant rounded half up from a fraction given in units of 1e-8.
  function automatic logic [63:0] fixed_const(input logic [63:0] whole, input logic [63:0] frac);
    logic [127:0] scaled;
    scaled = (({64'd0, frac} << (FRACTION_BITS + 1)) + 128'd100000000) / 128'd200000000;
    return (whole << FRACTION_BITS) + scaled[63:0];
  endfunction

  function automatic logic [63:0] fit_sign(input logic [63:0] mag, input logic neg,
                                           input logic ovf);
    if (neg) begin
      if (ovf || mag > MinValue) begin
        raise(ERR_SATURATE);
        return MinValue;
      end
      return -mag;
    end
    if (ovf || mag > MaxValue) begin
      raise(ERR_SATURATE);
      return MaxValue;
    end
    return mag;
  endfunction

  function automatic logic [63:0] fx_product(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb;
    logic [127:0] p;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p = ({64'd0, ma} * {64'd0, mb}) >> FRACTION_BITS;
    return fit_sign(p[63:0], a[63] ^ b[63], p[127:64] != 0);
  endfunction

  function automatic logic [63:0] fx_quotient(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb;
    logic [127:0] q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    if (mb == 0) begin
      raise(ERR_DIVZERO);
      return 64'd0;
    end
    q = ({64'd0, ma} << FRACTION_BITS) / {64'd0, mb};
    return fit_sign(q[63:0], a[63] ^ b[63], q[127:64] != 0);
  endfunction

  function automatic logic [63:0] fx_sum(input logic [63:0] a, input logic [63:0] b,
                                         input logic minus);
    logic [63:0] r;
    logic same;
    r = minus ? a - b : a + b;
    same = (a[63] == b[63]);
    if ((minus ? !same : same) && (r[63] != a[63])) begin
      raise(ERR_SATURATE);
      return a[63] ? MinValue : MaxValue;
    end
    return r;
  endfunction

  function automatic void push_val(input logic [63:0] v);
    if (val_depth >= STACK_DEPTH) raise(ERR_FULL);
    else val_stack[val_depth++] = v;
  endfunction

  function automatic void push_op(input logic [OpWidth-1:0] code);
    if (op_depth >= STACK_DEPTH) raise(ERR_FULL);
    else op_stack[op_depth++] = code;
  endfunction

  function automatic void apply_top_op();
    logic [OpWidth-1:0] op;
    logic [63:0] a, b, r;
    op = op_stack[--op_depth];
    if (val_depth < 2) begin
      raise(ERR_UNDERFLOW);
      return;
    end
    b = val_stack[--val_depth];
    a = val_stack[--val_depth];
    case (op)
      OPC_MUL: r = fx_product(a, b);
      OPC_DIV: r = fx_quotient(a, b);
      OPC_ADD: r = fx_sum(a, b, 1'b0);
      default: r = fx_sum(a, b, 1'b1);
    endcase
    val_stack[val_depth++] = r;
  endfunction

  function automatic void clear_state();
    op_depth = 0;
    val_depth = 0;
    first_error = ERR_NONE;
  endfunction

  function automatic void evaluate_token(input logic [3:0] act, input logic [63:0] num);
    logic [OpWidth-1:0] code;
    outcome_t o;
    case (act)
      ACT_NUMBER: push_val(num);
      ACT_PI: push_val(fixed_const(64'd3, 64'd14159265));
      ACT_E: push_val(fixed_const(64'd2, 64'd71828182));
      ACT_OPEN: push_op(OPC_OPEN);
      ACT_CLOSE: begin
        while (op_depth > 0 && op_stack[op_depth-1] != OPC_OPEN) apply_top_op();
        if (op_depth == 0) raise(ERR_CLOSE);
        else op_depth--;
      end
      ACT_MUL, ACT_DIV, ACT_ADD, ACT_SUB: begin
        case (act)
          ACT_MUL: code = OPC_MUL;
          ACT_DIV: code = OPC_DIV;
          ACT_ADD: code = OPC_ADD;
          default: code = OPC_SUB;
        endcase
        // Reduce while the stacked operator binds at least as tightly.
        while (op_depth > 0 && op_stack[op_depth-1] != OPC_OPEN &&
               (op_stack[op_depth-1] >> 1) <= (code >> 1))
          apply_top_op();
        push_op(code);
      end
      ACT_END: begin
        while (op_depth > 0) begin
          if (op_stack[op_depth-1] == OPC_OPEN) begin
            raise(ERR_OPEN);
            op_depth--;
          end else begin
            apply_top_op();
          end
        end
        if (val_depth == 0) begin
          raise(ERR_UNDERFLOW);
          o.value = 64'd0;
        end else begin
          o.value = val_stack[val_depth-1];
        end
        o.code = first_error;
        expected_outcomes.push_back(o);
        clear_state();
      end
      default: ;
    endcase
  endfunction

  initial begin
    fail_count = 0;
    checked_count = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (tok.valid && tok.ready) evaluate_token(tok.action, tok.number_value);
      if (res.valid && res.ready) begin
        if (expected_outcomes.size() == 0) begin
          report($sformatf("unexpected result %h err %0d", res.result_value, res.error_code));
        end else begin
          outcome_t o;
          o = expected_outcomes.pop_front();
          if (res.result_value !== o.value)
            report($sformatf("value %h, expected %h", res.result_value, o.value));
          if (res.error_code !== o.code)
            report($sformatf("error code %0d, expected %0d", res.error_code, o.code));
        end
        checked_count++;
      end
    end
  end
endmodule

// ===== bench/infix_expression_evaluator_tb.sv =====
// Top of the evaluator testbench: token stimulus, result sink, watchdog and verdict.
`timescale 1ns / 1ps
module infix_expression_evaluator_tb;
  import iee_pkg::*;

  localparam int TokenTarget = 1500;
  localparam int StallLimit  = 50000;

  typedef struct {
    logic [3:0]  act;
    logic [63:0] num;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  logic calm = 1'b0;
  int fail_count, pending_count, checked_count;
  int tokens_sent = 0;
  int idle_cycles = 0;
  token_t script[$];

  iee_token_if  tok_ch();
  iee_result_if res_ch();

  assign res_ch.ready = sink_ready;

  infix_expression_evaluator dut (.clk(clk), .rst(rst), .tok(tok_ch), .res(res_ch));

  iee_checker chk (
    .clk(clk), .rst(rst), .tok(tok_ch), .res(res_ch),
    .fail_count(fail_count), .pending_count(pending_count), .checked_count(checked_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) sink_ready <= 1'b0;
    else sink_ready <= calm || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    if ((tok_ch.valid && tok_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 6))
      0, 1: return {$urandom, $urandom};
      2: return 64'd0;
      3: return {$urandom_range(0, 40) - 20, $urandom};
      4: return {32'd0, $urandom};
      5: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
      default: return $urandom_range(0, 1) ? 64'h0000_0001_0000_0000 : 64'hFFFF_FFFF_0000_0000;
    endcase
  endfunction

  function automatic void add(input logic [3:0] act, input logic [63:0] num = 64'd0);
    token_t t;
    t.act = act;
    t.num = num;
    script.push_back(t);
  endfunction

  function automatic void add_operand();
    case ($urandom_range(0, 9))
      0: add(ACT_PI);
      1: add(ACT_E);
      default: add(ACT_NUMBER, pick_value());
    endcase
  endfunction

  function automatic void add_operator();
    case ($urandom_range(0, 3))
      0: add(ACT_MUL);
      1: add(ACT_DIV);
      2: add(ACT_ADD);
      default: add(ACT_SUB);
    endcase
  endfunction

  // Well-formed expression with random shape and content.
  function automatic void build_expr(input int depth);
    int pick;
    pick = $urandom_range(0, 9);
    if (depth == 0 || pick < 3) begin
      add_operand();
    end else if (pick < 5) begin
      add(ACT_OPEN);
      build_expr(depth - 1);
      add(ACT_CLOSE);
    end else begin
      build_expr(depth - 1);
      add_operator();
      build_expr(depth - 1);
    end
  endfunction

  task automatic send_script();
    token_t t;
    while (script.size() > 0) begin
      t = script.pop_front();
      while (!calm && $urandom_range(0, 99) < 34) begin
        tok_ch.valid <= 1'b0;
        @(posedge clk);
      end
      tok_ch.valid <= 1'b1;
      tok_ch.action <= t.act;
      tok_ch.number_value <= t.num;
      @(posedge clk);
      while (!tok_ch.ready) @(posedge clk);
      tokens_sent++;
    end
  endtask

  initial begin
    int n;
    tok_ch.valid = 1'b0;
    tok_ch.action = ACT_NUMBER;
    tok_ch.number_value = 64'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty result, saturation, divide by zero, unmatched brackets,
    // underflow, extra values and an unknown token.
    add(ACT_END);
    add(ACT_NUMBER, 64'h7FFF_FFFF_FFFF_FFFF); add(ACT_ADD);
    add(ACT_NUMBER, 64'h7FFF_FFFF_FFFF_FFFF); add(ACT_END);
    add(ACT_PI); add(ACT_DIV); add(ACT_NUMBER, 64'd0); add(ACT_END);
    add(ACT_CLOSE); add(ACT_END);
    add(ACT_OPEN); add(ACT_E); add(ACT_MUL);
    add(ACT_NUMBER, 64'h8000_0000_0000_0000); add(ACT_END);
    add(ACT_SUB); add(ACT_NUMBER, 64'h0000_0001_0000_0000); add(ACT_END);
    add(ACT_NUMBER, 64'hFFFF_FFFF_FFFF_FFFF); add(ACT_NUMBER, 64'd5); add(ACT_END);
    add(4'd15); add(ACT_END);
    send_script();

    // Let the sender wait until every result has drained.
    tok_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);

    while (tokens_sent < TokenTarget) begin
      calm = (tokens_sent >= 600 && tokens_sent < 900);
      if ($urandom_range(0, 9) < 8) begin
        build_expr($urandom_range(0, 4));
      end else if ($urandom_range(0, 3) == 0) begin
        // Enough pushes of one kind to overrun a stack.
        n = $urandom_range(17, 20);
        if ($urandom_range(0, 1)) begin
          for (int i = 0; i < n; i++) add(ACT_OPEN);
        end else begin
          for (int i = 0; i < n; i++) add_operand();
        end
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) add(4'($urandom_range(0, 15)), pick_value());
      end
      add(ACT_END);
      send_script();
    end
    calm = 1'b0;
    tok_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d tokens: nested and flat expressions, saturating and", tokens_sent);
    $display("faulty cases, stack overruns; %0d results compared.", checked_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
